// ===== hw/rtl/plcu_pkg.sv =====
// ============================================================================
// plcu_pkg: shared constants and types for the Phong lighting color unit
// Fixed-point formats, normalizer geometry, register map and reset values.
// ============================================================================
package plcu_pkg;

    // Defaults for the top level parameters
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int NORMAL_WIDTH_DEF = 16;
    localparam int EXP_BITS_DEF     = 8;

    // Q1.14 unit vectors
    localparam int FRAC_BITS = 14;
    localparam int Q_ONE     = 16384;
    localparam int UNIT_W    = 16;

    // Vector normalizer geometry
    localparam int NORM_BITS  = 30;              // magnitudes scaled into [2^29, 2^30)
    localparam int SQ_W       = 2 * NORM_BITS + 2; // sum of three squares
    localparam int LEN_W      = NORM_BITS + 1;   // floor(sqrt(sum))
    localparam int SQRT_STEPS = 31;              // one root bit per stage
    localparam int DIV_STEPS  = 15;              // one quotient bit per stage
    localparam int NORM_LAT   = 6 + SQRT_STEPS + DIV_STEPS + 1;

    // Reflection vector before normalization (Q3.28)
    localparam int RRAW_W = 32;

    localparam int CHAN_MAX = 255;

    typedef logic signed [UNIT_W-1:0] unit_t;

    // Register map, word addressed
    localparam int CFG_ADDR_W = 5;
    typedef enum logic [2:0] {
        CFG_LIGHT_X   = 3'd0,
        CFG_LIGHT_Y   = 3'd1,
        CFG_LIGHT_Z   = 3'd2,
        CFG_AMBIENT   = 3'd3,
        CFG_DIFFUSE   = 3'd4,
        CFG_SPECULAR  = 3'd5,
        CFG_SHININESS = 3'd6,
        CFG_MODE      = 3'd7
    } cfg_reg_t;

    localparam logic signed [15:0] LIGHT_X_RST = 16'sd0;
    localparam logic signed [15:0] LIGHT_Y_RST = 16'sd0;
    localparam logic signed [15:0] LIGHT_Z_RST = 16'sd16384;
    localparam logic [8:0] AMBIENT_RST   = 9'd26;
    localparam logic [8:0] DIFFUSE_RST   = 9'd179;
    localparam logic [8:0] SPECULAR_RST  = 9'd51;
    localparam logic [7:0] SHININESS_RST = 8'd64;
    localparam logic       MODE_RST      = 1'b0;

endpackage

// ===== hw/rtl/plcu_unit_vec.sv =====
// ============================================================================
// plcu_unit_vec: pipelined 3-vector normalizer
// Scales to a common range, takes an integer square root and divides each
// component by the length, one root or quotient bit per stage.
// ============================================================================
module plcu_unit_vec #(
    parameter int IN_WIDTH = 17
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [IN_WIDTH-1:0] in_vec [3],
    output plcu_pkg::unit_t            out_vec [3]
);
    import plcu_pkg::*;

    localparam int POS_W    = $clog2(IN_WIDTH + 1);
    localparam int EXT_W    = IN_WIDTH + NORM_BITS;
    localparam int ACC_W    = SQ_W + 1;
    localparam int REM_W    = LEN_W + 1;
    localparam int SIDE_LEN = NORM_LAT - 3;
    localparam int NMAG_LEN = SQRT_STEPS + 3;

    function automatic logic [ACC_W-1:0] root_bit(input int j);
        return ACC_W'(1) << (SQ_W - 2 - 2 * j);
    endfunction

    // magnitudes, maximum, leading one
    logic [IN_WIDTH-1:0] mag1_reg [3];
    logic [IN_WIDTH-1:0] mag2_reg [3];
    logic [IN_WIDTH-1:0] mag3_reg [3];
    logic [2:0]          neg1_reg, neg2_reg;
    logic [IN_WIDTH-1:0] max2_reg, max_c;
    logic [POS_W-1:0]    pos_c, sh3_reg;
    logic [3:0]          side_reg [SIDE_LEN];   // {zero, neg[2:0]}

    // scaled magnitudes, squares, root
    logic [NORM_BITS-1:0]   nmag_reg [NMAG_LEN][3];
    logic [EXT_W-1:0]       ext_c [3];
    logic [2*NORM_BITS-1:0] sq_reg [3];
    logic [SQ_W-1:0]        sx_reg [SQRT_STEPS+1];
    logic [ACC_W-1:0]       sr_reg [SQRT_STEPS+1];

    // division
    logic [LEN_W-1:0]     dlen_reg [DIV_STEPS];
    logic [REM_W-1:0]     drem_reg [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] dq_reg [DIV_STEPS][3];
    logic [LEN_W-1:0]     len_c [DIV_STEPS];
    logic [REM_W-1:0]     rprev_c [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] qprev_c [DIV_STEPS][3];
    logic                 bin_c [DIV_STEPS][3];
    logic [REM_W-1:0]     trial_c [DIV_STEPS][3];
    unit_t                qs_c [3];
    unit_t                out_reg [3];

    always_comb begin
        max_c = mag1_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (mag1_reg[i] > max_c) max_c = mag1_reg[i];
        end
    end

    always_comb begin
        pos_c = '0;
        for (int b = 0; b < IN_WIDTH; b++) begin
            if (max2_reg[b]) pos_c = POS_W'(b);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext_c[i] = {mag3_reg[i], {NORM_BITS{1'b0}}} >> sh3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= in_vec[i][IN_WIDTH-1];
                mag1_reg[i] <= in_vec[i][IN_WIDTH-1] ? unsigned'(-in_vec[i])
                                                     : unsigned'(in_vec[i]);
                mag2_reg[i] <= mag1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                nmag_reg[0][i] <= ext_c[i][NORM_BITS-1:0];
                sq_reg[i] <= nmag_reg[0][i] * nmag_reg[0][i];
            end
            neg2_reg <= neg1_reg;
            max2_reg <= max_c;
            sh3_reg <= pos_c + POS_W'(1);
            side_reg[0] <= {(max2_reg == '0), neg2_reg};
            for (int k = 1; k < SIDE_LEN; k++) side_reg[k] <= side_reg[k-1];
            for (int k = 1; k < NMAG_LEN; k++) nmag_reg[k] <= nmag_reg[k-1];
            sx_reg[0] <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            sr_reg[0] <= '0;
        end
    end

    // integer square root, one bit pair per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < SQRT_STEPS; j++) begin
                if (ACC_W'(sx_reg[j]) >= sr_reg[j] + root_bit(j)) begin
                    sx_reg[j+1] <= SQ_W'(ACC_W'(sx_reg[j]) - (sr_reg[j] + root_bit(j)));
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + root_bit(j);
                end else begin
                    sx_reg[j+1] <= sx_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
            end
        end
    end

    // restoring division of mag * 2^14 by len
    always_comb begin
        len_c[0] = LEN_W'(sr_reg[SQRT_STEPS]);
        for (int i = 0; i < 3; i++) begin
            rprev_c[0][i] = REM_W'(nmag_reg[NMAG_LEN-1][i] >> 1);
            bin_c[0][i]   = nmag_reg[NMAG_LEN-1][i][0];
            qprev_c[0][i] = '0;
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            len_c[k] = dlen_reg[k-1];
            for (int i = 0; i < 3; i++) begin
                rprev_c[k][i] = drem_reg[k-1][i];
                bin_c[k][i]   = 1'b0;
                qprev_c[k][i] = dq_reg[k-1][i];
            end
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int i = 0; i < 3; i++) begin
                trial_c[k][i] = {rprev_c[k][i][REM_W-2:0], bin_c[k][i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                dlen_reg[k] <= len_c[k];
                for (int i = 0; i < 3; i++) begin
                    if (trial_c[k][i] >= REM_W'(len_c[k])) begin
                        drem_reg[k][i] <= trial_c[k][i] - REM_W'(len_c[k]);
                        dq_reg[k][i]   <= {qprev_c[k][i][DIV_STEPS-2:0], 1'b1};
                    end else begin
                        drem_reg[k][i] <= trial_c[k][i];
                        dq_reg[k][i]   <= {qprev_c[k][i][DIV_STEPS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qs_c[i] = unit_t'({1'b0, dq_reg[DIV_STEPS-1][i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (side_reg[SIDE_LEN-1][3]) begin
                    out_reg[i] <= '0;
                end else if (side_reg[SIDE_LEN-1][i]) begin
                    out_reg[i] <= -qs_c[i];
                end else begin
                    out_reg[i] <= qs_c[i];
                end
            end
        end
    end

    assign out_vec = out_reg;

endmodule

// ===== hw/rtl/phong_lighting_color_unit_top.sv =====
// ============================================================================
// phong_lighting_color_unit_top: Phong shading, one directional light
// Normalizes the surface normal, forms the Lambert term, the reflected light
// and view vectors, raises R.V to the shininess and scales the ARGB color.
// ============================================================================
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+--------------------------
//  s_       | in        | s_tvalid / s_tready      | normal, point, camera, ARGB
//  m_       | out       | m_tvalid / m_tready      | lit ARGB
//  cfg      | in        | psel/penable/pwrite      | 8 registers at 4*index
//
//  One transaction per clock sustained while the output is not stalled.
//  The path runs through two normalizers in series (31 root stages + 15
//  divide stages each). Reset (aresetn low, synchronous) clears stage
//  valids and the output and skid valid flags and loads register defaults.
//  A stall on m_tready freezes the whole pipe once the skid register fills;
//  s_tready is registered.
//
module phong_lighting_color_unit_top #(
    parameter int COORD_WIDTH  = plcu_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = plcu_pkg::NORMAL_WIDTH_DEF,
    parameter int EXP_BITS     = plcu_pkg::EXP_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // tdata, low bit first: normal_x, normal_y, normal_z, point_x, point_y,
    // point_z, camera_x, camera_y, camera_z, base_color, zero pad to bytes
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [(((3*NORMAL_WIDTH + 6*COORD_WIDTH + 32) + 7) / 8) * 8 - 1:0] s_tdata,

    // tdata: lit_color
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plcu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import plcu_pkg::*;

    // tdata field offsets
    localparam int OFF_N   = 0;
    localparam int OFF_P   = 3 * NORMAL_WIDTH;
    localparam int OFF_C   = OFF_P + 3 * COORD_WIDTH;
    localparam int OFF_COL = OFF_C + 3 * COORD_WIDTH;

    localparam int V_W     = COORD_WIDTH + 1;
    localparam int NL      = NORM_LAT;
    localparam int COL_LEN = 2 * NL + 4;
    localparam int V_DLY   = NL + 4;
    localparam int IE_LEN  = NL;
    localparam int PD_LEN  = EXP_BITS + 2;
    localparam int LAST    = 2 * NL + 8 + EXP_BITS;

    localparam int PROD_W  = 2 * UNIT_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int D_W     = FRAC_BITS + 1;
    localparam int DT_W    = 9 + D_W;
    localparam int INT_W   = 10;
    localparam int CHP_W   = 8 + INT_W;
    localparam int SP_W    = 9 + D_W;

    typedef struct packed {
        logic             spec_en;
        logic [INT_W-1:0] inten;
    } shade_t;

    typedef struct packed {
        logic [7:0]  alpha;
        logic [23:0] ch;
        logic        spec_en;
    } pix_t;

    // ---------------- configuration registers ----------------
    logic signed [15:0] light_reg [3];
    logic [8:0]         ambient_reg, diffuse_reg, specular_reg;
    logic [7:0]         shininess_reg;
    logic               mode_reg;
    cfg_reg_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg[0]  <= LIGHT_X_RST;
            light_reg[1]  <= LIGHT_Y_RST;
            light_reg[2]  <= LIGHT_Z_RST;
            ambient_reg   <= AMBIENT_RST;
            diffuse_reg   <= DIFFUSE_RST;
            specular_reg  <= SPECULAR_RST;
            shininess_reg <= SHININESS_RST;
            mode_reg      <= MODE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (cfg_sel)
                CFG_LIGHT_X:   light_reg[0]  <= pwdata[15:0];
                CFG_LIGHT_Y:   light_reg[1]  <= pwdata[15:0];
                CFG_LIGHT_Z:   light_reg[2]  <= pwdata[15:0];
                CFG_AMBIENT:   ambient_reg   <= pwdata[8:0];
                CFG_DIFFUSE:   diffuse_reg   <= pwdata[8:0];
                CFG_SPECULAR:  specular_reg  <= pwdata[8:0];
                CFG_SHININESS: shininess_reg <= pwdata[7:0];
                CFG_MODE:      mode_reg      <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            CFG_LIGHT_X:   prdata = 32'(unsigned'(light_reg[0]));
            CFG_LIGHT_Y:   prdata = 32'(unsigned'(light_reg[1]));
            CFG_LIGHT_Z:   prdata = 32'(unsigned'(light_reg[2]));
            CFG_AMBIENT:   prdata = 32'(ambient_reg);
            CFG_DIFFUSE:   prdata = 32'(diffuse_reg);
            CFG_SPECULAR:  prdata = 32'(specular_reg);
            CFG_SHININESS: prdata = 32'(shininess_reg);
            CFG_MODE:      prdata = 32'(mode_reg);
        endcase
    end

    // ---------------- pipeline control ----------------
    // All stages move together on en; en drops only while the skid holds data.
    logic            en;
    logic [LAST:0]   vld_reg;
    logic            out_valid_reg, skid_valid_reg;
    logic [31:0]     out_data_reg, skid_data_reg;
    logic [31:0]     lit_c;
    logic            xfer_in;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign xfer_in  = en && vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
        end
    end

    // ---------------- stage 0: input capture ----------------
    logic signed [NORMAL_WIDTH-1:0] nraw0_reg [3];
    logic signed [COORD_WIDTH-1:0]  pt0_reg [3], cam0_reg [3];
    logic [31:0]                    col0_reg;
    logic signed [V_W-1:0]          vraw_c [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nraw0_reg[i] <= s_tdata[OFF_N + i*NORMAL_WIDTH +: NORMAL_WIDTH];
                pt0_reg[i]   <= s_tdata[OFF_P + i*COORD_WIDTH +: COORD_WIDTH];
                cam0_reg[i]  <= s_tdata[OFF_C + i*COORD_WIDTH +: COORD_WIDTH];
            end
            col0_reg <= s_tdata[OFF_COL +: 32];
        end
    end

    // view vector: camera minus point, one bit wider
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vraw_c[i] = V_W'(cam0_reg[i]) - V_W'(pt0_reg[i]);
        end
    end

    unit_t nunit [3];
    unit_t vunit [3];
    unit_t runit [3];

    plcu_unit_vec #(.IN_WIDTH(NORMAL_WIDTH)) u_norm_n (
        .aclk    (aclk),
        .en      (en),
        .in_vec  (nraw0_reg),
        .out_vec (nunit)
    );

    plcu_unit_vec #(.IN_WIDTH(V_W)) u_norm_v (
        .aclk    (aclk),
        .en      (en),
        .in_vec  (vraw_c),
        .out_vec (vunit)
    );

    // color rides along until the final scaling
    logic [31:0] col_d_reg [COL_LEN];
    unit_t       v_d_reg [V_DLY][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            col_d_reg[0] <= col0_reg;
            for (int k = 1; k < COL_LEN; k++) col_d_reg[k] <= col_d_reg[k-1];
            v_d_reg[0] <= vunit;
            for (int k = 1; k < V_DLY; k++) v_d_reg[k] <= v_d_reg[k-1];
        end
    end

    // ---------------- Lambert term and reflection ----------------
    logic signed [PROD_W-1:0] prod1_reg [3];
    unit_t                    n1_reg [3], n2_reg [3];
    logic [D_W-1:0]           d2_reg, d3_reg, d_c;
    logic signed [DOT_W-1:0]  t_c, negt_c;
    logic [DT_W-1:0]          dterm3_reg;
    logic signed [PROD_W-1:0] dn3_reg [3];
    logic signed [RRAW_W-1:0] rraw4_reg [3];
    shade_t                   shade4_reg;
    logic [INT_W-1:0]         inten_c;
    shade_t                   ie_d_reg [IE_LEN];

    always_comb begin
        t_c    = DOT_W'(prod1_reg[0]) + DOT_W'(prod1_reg[1]) + DOT_W'(prod1_reg[2]);
        negt_c = -t_c;
        d_c    = '0;
        if (t_c < 0) begin
            if (negt_c[DOT_W-1:FRAC_BITS] > (DOT_W-FRAC_BITS)'(Q_ONE)) begin
                d_c = D_W'(Q_ONE);
            end else begin
                d_c = negt_c[FRAC_BITS +: D_W];
            end
        end
        inten_c = INT_W'(ambient_reg) + INT_W'(dterm3_reg[DT_W-1:FRAC_BITS]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod1_reg[i] <= nunit[i] * light_reg[i];
                n1_reg[i]    <= nunit[i];
                n2_reg[i]    <= n1_reg[i];
                dn3_reg[i]   <= $signed({1'b0, d2_reg}) * n2_reg[i];
                rraw4_reg[i] <= (RRAW_W'(dn3_reg[i]) <<< 1)
                              + (RRAW_W'(light_reg[i]) <<< FRAC_BITS);
            end
            d2_reg     <= d_c;
            d3_reg     <= d2_reg;
            dterm3_reg <= diffuse_reg * d2_reg;
            // flat mode clamps intensity to one
            if (!mode_reg && inten_c > INT_W'(256)) begin
                shade4_reg.inten <= INT_W'(256);
            end else begin
                shade4_reg.inten <= inten_c;
            end
            shade4_reg.spec_en <= (d3_reg != '0) && (specular_reg != '0)
                                && (shininess_reg != '0) && mode_reg;
            ie_d_reg[0] <= shade4_reg;
            for (int k = 1; k < IE_LEN; k++) ie_d_reg[k] <= ie_d_reg[k-1];
        end
    end

    plcu_unit_vec #(.IN_WIDTH(RRAW_W)) u_norm_r (
        .aclk    (aclk),
        .en      (en),
        .in_vec  (rraw4_reg),
        .out_vec (runit)
    );

    // ---------------- R.V and channel scaling ----------------
    logic signed [PROD_W-1:0] u1_reg [3];
    logic [CHP_W-1:0]         chp1_reg [3];
    logic                     spec1_reg;
    logic [7:0]               alpha1_reg;
    logic signed [DOT_W-1:0]  u_c;
    logic [D_W-1:0]           p_c, p2_reg;
    logic [7:0]               ch_c [3];
    pix_t                     pix2_reg;
    logic [31:0]              colb_c;

    assign colb_c = col_d_reg[COL_LEN-1];

    always_comb begin
        u_c = DOT_W'(u1_reg[0]) + DOT_W'(u1_reg[1]) + DOT_W'(u1_reg[2]);
        p_c = '0;
        if (u_c > 0) begin
            if (u_c[DOT_W-1:FRAC_BITS] > (DOT_W-FRAC_BITS)'(Q_ONE)) begin
                p_c = D_W'(Q_ONE);
            end else begin
                p_c = u_c[FRAC_BITS +: D_W];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (chp1_reg[i][CHP_W-1:8] > (CHP_W-8)'(CHAN_MAX)) begin
                ch_c[i] = 8'(CHAN_MAX);
            end else begin
                ch_c[i] = chp1_reg[i][15:8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u1_reg[i]   <= runit[i] * v_d_reg[V_DLY-1][i];
                chp1_reg[i] <= colb_c[16 - 8*i +: 8] * ie_d_reg[IE_LEN-1].inten;
            end
            spec1_reg        <= ie_d_reg[IE_LEN-1].spec_en;
            alpha1_reg       <= colb_c[31:24];
            p2_reg           <= p_c;
            pix2_reg.alpha   <= alpha1_reg;
            pix2_reg.ch      <= {ch_c[0], ch_c[1], ch_c[2]};
            // no highlight when R and V do not face each other
            pix2_reg.spec_en <= spec1_reg && (u_c > 0);
        end
    end

    // ---------------- power by squaring, one exponent bit per stage ----------------
    logic [EXP_BITS-1:0]  exp_bits;
    logic [D_W-1:0]       res_in_c [EXP_BITS], base_in_c [EXP_BITS];
    logic [D_W-1:0]       pw_res_reg [EXP_BITS], pw_base_reg [EXP_BITS];
    logic [2*D_W-1:0]     rb_c [EXP_BITS], bb_c [EXP_BITS];
    pix_t                 pd_reg [PD_LEN];
    logic [SP_W-1:0]      sprod_reg;
    logic [7:0]           spec_reg;
    logic [17:0]          spec_c;

    assign exp_bits = EXP_BITS'(shininess_reg);

    always_comb begin
        res_in_c[0]  = D_W'(Q_ONE);
        base_in_c[0] = p2_reg;
        for (int e = 1; e < EXP_BITS; e++) begin
            res_in_c[e]  = pw_res_reg[e-1];
            base_in_c[e] = pw_base_reg[e-1];
        end
        for (int e = 0; e < EXP_BITS; e++) begin
            rb_c[e] = res_in_c[e] * base_in_c[e];
            bb_c[e] = base_in_c[e] * base_in_c[e];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int e = 0; e < EXP_BITS; e++) begin
                pw_res_reg[e]  <= exp_bits[e] ? rb_c[e][FRAC_BITS +: D_W] : res_in_c[e];
                pw_base_reg[e] <= bb_c[e][FRAC_BITS +: D_W];
            end
            pd_reg[0] <= pix2_reg;
            for (int k = 1; k < PD_LEN; k++) pd_reg[k] <= pd_reg[k-1];
            sprod_reg <= specular_reg * pw_res_reg[EXP_BITS-1];
            if (!pd_reg[PD_LEN-2].spec_en) begin
                spec_reg <= '0;
            end else if (spec_c[17:8] > 10'(CHAN_MAX)) begin
                spec_reg <= 8'(CHAN_MAX);
            end else begin
                spec_reg <= spec_c[15:8];
            end
        end
    end

    // white specular: 255 scaled by S in 1/256 units
    assign spec_c = 18'(CHAN_MAX) * 18'(sprod_reg[SP_W-1:FRAC_BITS]);

    // ---------------- final add and output skid ----------------
    logic [8:0] sum_c [3];
    logic [7:0] out_ch_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_c[i] = 9'(pd_reg[PD_LEN-1].ch[16 - 8*i +: 8]) + 9'(spec_reg);
            out_ch_c[i] = sum_c[i][8] ? 8'(CHAN_MAX) : sum_c[i][7:0];
        end
        lit_c = {pd_reg[PD_LEN-1].alpha, out_ch_c[0], out_ch_c[1], out_ch_c[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg) begin
                if (m_tready) skid_valid_reg <= 1'b0;
            end else if (xfer_in) begin
                if (!out_valid_reg || m_tready) out_valid_reg <= 1'b1;
                else skid_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (skid_valid_reg) begin
            if (m_tready) out_data_reg <= skid_data_reg;
        end else if (xfer_in) begin
            if (!out_valid_reg || m_tready) out_data_reg <= lit_c;
            else skid_data_reg <= lit_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/plcu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plcu_checker: shading predictor and result comparator
// Watches config writes and both stream channels, computes the expected lit
// color of every accepted fragment and compares it with the output stream.
// ----------------------------------------------------------------------------
module plcu_checker
    import plcu_pkg::*;
#(
    parameter int DW = 272
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [DW-1:0] s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [31:0]   m_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    output int            fail_count,
    output int            pending
);

    logic signed [15:0] lx, ly, lz;
    logic [8:0] amb, dif, spc;
    logic [7:0] shin;
    logic mode;
    logic [31:0] color_q[$];

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q1.14 unit vector, zero in gives zero out
    task automatic normalize(input longint vi[3], output longint vo[3]);
        logic [63:0] mag[3];
        logic [63:0] m, s, len;
        bit neg[3];
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = vi[i] < 0;
            mag[i] = neg[i] ? -vi[i] : vi[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            vo = '{0, 0, 0};
            return;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
        len = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            m = (mag[i] * Q_ONE) / len;
            vo[i] = neg[i] ? -longint'(m) : longint'(m);
        end
    endtask

    function automatic logic [31:0] sat_scale(input logic [31:0] c, input logic [31:0] k);
        logic [31:0] v;
        v = (c * k) >> 8;
        return v > 255 ? 32'd255 : v;
    endfunction

    task automatic shade(input logic [DW-1:0] d, output logic [31:0] lit);
        longint nr[3], n[3], lv[3], rr[3], r[3], vr[3], v[3], t, u;
        logic [63:0] lam, p, res, bs;
        logic [31:0] dt, inten, sp, ch[3], col;
        lv = '{longint'(lx), longint'(ly), longint'(lz)};
        for (int i = 0; i < 3; i++) nr[i] = longint'($signed(d[16*i +: 16]));
        normalize(nr, n);
        t = n[0]*lv[0] + n[1]*lv[1] + n[2]*lv[2];
        lam = 0;
        if (t < 0) begin
            lam = (-t) >> 14;
            if (lam > Q_ONE) lam = Q_ONE;
        end
        dt = (dif * lam) >> 14;
        col = d[240 +: 32];
        for (int i = 0; i < 3; i++) ch[i] = (col >> (16 - 8*i)) & 32'hFF;
        inten = amb + dt;
        if (!mode && inten > 256) inten = 256;
        for (int i = 0; i < 3; i++) ch[i] = sat_scale(ch[i], inten);
        if (mode) begin
            sp = 0;
            if (lam > 0 && spc > 0 && shin > 0) begin
                for (int i = 0; i < 3; i++) begin
                    rr[i] = 2 * longint'(lam) * n[i] + lv[i] * Q_ONE;
                    vr[i] = longint'($signed(d[144 + 32*i +: 32]))
                          - longint'($signed(d[48 + 32*i +: 32]));
                end
                normalize(rr, r);
                normalize(vr, v);
                u = r[0]*v[0] + r[1]*v[1] + r[2]*v[2];
                if (u > 0) begin
                    p = u >> 14;
                    if (p > Q_ONE) p = Q_ONE;
                    res = Q_ONE;
                    bs = p;
                    for (int i = 0; i < 8; i++) begin
                        if (shin[i]) res = (res * bs) >> 14;
                        bs = (bs * bs) >> 14;
                    end
                    sp = sat_scale(255, (spc * res) >> 14);
                end
            end
            for (int i = 0; i < 3; i++) begin
                ch[i] = ch[i] + sp;
                if (ch[i] > 255) ch[i] = 255;
            end
        end
        lit = {col[31:24], ch[0][7:0], ch[1][7:0], ch[2][7:0]};
    endtask

    assign pending = color_q.size();

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            lx <= LIGHT_X_RST;
            ly <= LIGHT_Y_RST;
            lz <= LIGHT_Z_RST;
            amb <= AMBIENT_RST;
            dif <= DIFFUSE_RST;
            spc <= SPECULAR_RST;
            shin <= SHININESS_RST;
            mode <= MODE_RST;
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[4:2]))
                    CFG_LIGHT_X:   lx <= pwdata[15:0];
                    CFG_LIGHT_Y:   ly <= pwdata[15:0];
                    CFG_LIGHT_Z:   lz <= pwdata[15:0];
                    CFG_AMBIENT:   amb <= pwdata[8:0];
                    CFG_DIFFUSE:   dif <= pwdata[8:0];
                    CFG_SPECULAR:  spc <= pwdata[8:0];
                    CFG_SHININESS: shin <= pwdata[7:0];
                    CFG_MODE:      mode <= pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                shade(s_tdata, want);
                color_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (color_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = color_q.pop_front();
                    if (want !== m_tdata) begin
                        if (fail_count < 10)
                            $display("lit_color exp %h got %h", want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: Phong lighting color unit stimulus
// Programs light and material registers over APB, streams directed and
// random fragments with random idling on both sides; checker gives verdict.
// ----------------------------------------------------------------------------
module testbench;
    import plcu_pkg::*;

    localparam int DW = 272;
    localparam int LAT = 123;
    localparam int WATCHDOG = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count, pending;
    int idle_cycles = 0;
    bit calm = 0;   // no idling on either side while set

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    phong_lighting_color_unit_top dut (.*);

    plcu_checker #(.DW(DW)) chk (.*);

    // Sink: random backpressure, ~20% stalled unless in the calm stretch
    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 20);

    // Watchdog: cycles with no transaction on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("phong_lighting_color_unit_top: mismatch");
            $finish;
        end
    end

    task automatic reg_write(input cfg_reg_t r, input logic [31:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Stop sending, wait for every expected color, then let the pipe drain fully
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
    endtask

    // Leaves s_tvalid high after the transaction; drain drops it, the next send drops it only to idle
    task automatic send(input logic [DW-1:0] d);
        while (!calm && $urandom_range(99) < 20) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [DW-1:0] frag(input logic [15:0] nx, ny, nz,
                                           input logic [31:0] px, py, pz,
                                           input logic [31:0] cx, cy, cz,
                                           input logic [31:0] col);
        return {16'h0, col, cz, cy, cx, pz, py, px, nz, ny, nx};
    endfunction

    function automatic logic [15:0] rnd16();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random fragment: mostly modest coordinates, sometimes full range
    function automatic logic [DW-1:0] rnd_frag();
        logic [31:0] c[6];
        for (int i = 0; i < 6; i++)
            c[i] = ($urandom_range(3) == 0) ? $urandom
                 : 32'($signed($urandom_range(2000000)) - 1000000);
        return frag(rnd16(), rnd16(), rnd16(), c[0], c[1], c[2], c[3], c[4], c[5],
                    $urandom);
    endfunction

    task automatic rnd_config();
        int a, b, c;
        logic signed [15:0] q[3];
        // random direction of at most unit length, with axis-aligned and non-unit cases now and then
        case ($urandom_range(5))
            0: q = '{16'sd0, 16'sd0, -16'sd16384};
            1: q = '{16'sd16384, 16'sd0, 16'sd0};
            2: q = '{16'($urandom), 16'($urandom), 16'($urandom)};
            default: begin
                a = $urandom_range(18918) - 9459;
                b = $urandom_range(18918) - 9459;
                c = $urandom_range(18918) - 9459;
                q = '{16'(a), 16'(b), 16'(c)};
                if (a == 0 && b == 0 && c == 0) q[2] = -16'sd16384;
            end
        endcase
        reg_write(CFG_LIGHT_X, {{16{q[0][15]}}, q[0]});
        reg_write(CFG_LIGHT_Y, {{16{q[1][15]}}, q[1]});
        reg_write(CFG_LIGHT_Z, {{16{q[2][15]}}, q[2]});
        reg_write(CFG_AMBIENT, $urandom_range(3) == 0 ? $urandom : $urandom_range(256));
        reg_write(CFG_DIFFUSE, $urandom_range(3) == 0 ? $urandom : $urandom_range(256));
        reg_write(CFG_SPECULAR, $urandom_range(3) == 0 ? $urandom : $urandom_range(256));
        reg_write(CFG_SHININESS, $urandom_range(255));
        reg_write(CFG_MODE, $urandom_range(3) != 0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: lit mode, light straight down, extremes and special cases
        reg_write(CFG_LIGHT_X, 0);
        reg_write(CFG_LIGHT_Y, 0);
        reg_write(CFG_LIGHT_Z, 32'hFFFF_C000);
        reg_write(CFG_AMBIENT, 256);
        reg_write(CFG_DIFFUSE, 256);
        reg_write(CFG_SPECULAR, 256);
        reg_write(CFG_SHININESS, 1);
        reg_write(CFG_MODE, 1);
        send(frag(0, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 32'hFFFFFFFF));       // zero normal
        send(frag(0, 0, 16'h7FFF, 0, 0, 0, 0, 0, 32'h10000, 32'hFF80FF00));
        send(frag(0, 0, 16'h8000, 0, 0, 0, 0, 0, 32'h10000, 32'h12345678)); // facing away
        send(frag(0, 0, 1, 5, 5, 5, 5, 5, 5, 32'hFFFFFFFF));                 // point at camera
        send(frag(16'h8000, 16'h8000, 16'h8000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
        send(frag(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF));
        send(frag(1, 0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 32'hA5A5A5A5));
        drain();
        reg_write(CFG_SHININESS, 255);
        reg_write(CFG_AMBIENT, 511);
        reg_write(CFG_DIFFUSE, 511);
        reg_write(CFG_SPECULAR, 511);
        reg_write(CFG_LIGHT_X, 32'h7FFF);        // not unit: saturates
        send(frag(16'h8000, 0, 16'h7FFF, 0, 0, 0, 0, 0, 32'h10000, 32'hFFFFFFFF));
        send(frag(0, 0, 16'h7FFF, 0, 0, 0, 0, 0, 32'h10000, 32'h80808080));
        drain();
        reg_write(CFG_SHININESS, 0);             // no specular
        send(frag(0, 0, 16'h7FFF, 0, 0, 0, 0, 0, 32'h10000, 32'hFFFFFFFF));
        drain();
        reg_write(CFG_MODE, 0);                  // flat, clamped to one
        send(frag(0, 0, 16'h7FFF, 0, 0, 0, 0, 0, 32'h10000, 32'hFFFFFFFF));
        send(frag(0, 0, 16'h8000, 0, 0, 0, 0, 0, 32'h10000, 32'hFF7F3F1F));
        drain();
        reg_write(CFG_AMBIENT, 0);
        reg_write(CFG_DIFFUSE, 0);
        send(frag(0, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
        drain();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < 13; ph++) begin
            rnd_config();
            calm = (ph == 5);
            for (int k = 0; k < 150; k++) send(rnd_frag());
            drain();
        end
        calm = 0;
        drain();

        if (fail_count == 0)
            $display("phong_lighting_color_unit_top: match");
        else
            $display("phong_lighting_color_unit_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/plcu_pkg.sv
hw/rtl/plcu_unit_vec.sv
hw/rtl/phong_lighting_color_unit_top.sv
tb/plcu_checker.sv
tb/testbench.sv
